// File: hdl/hsrs_pkg.sv
// Package: shared types and constants of the heapsort record store.
package hsrs_pkg;
   localparam int IdWidth  = 32;
   localparam int KeyWidth = 9;
   localparam logic [KeyWidth-1:0] KeyMax = 9'd400;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_ENTRY    = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_DUMP   = 1'b1;

   typedef struct packed {
      logic                kind;
      logic [IdWidth-1:0]  new_id;
      logic [KeyWidth-1:0] new_key;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [IdWidth-1:0]  out_id;
      logic [KeyWidth-1:0] out_key;
      logic                last;
   } rsp_type;
endpackage

// File: hdl/hsrs_req_if.sv
// Interface: request channel of the record store.
interface hsrs_req_if;
   logic              valid;
   logic              ready;
   hsrs_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/hsrs_rsp_if.sv
// Interface: response channel of the record store.
interface hsrs_rsp_if;
   logic              valid;
   logic              ready;
   hsrs_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/heapsort_record_store_by_key.sv
// Top level: record store kept sorted by key with a heapsort over one memory.
//
// Use: requests arrive on req (valid/ready). kind 0 inserts (new_id, new_key),
// clamping keys above 400; kind 1 dumps all entries highest key first, each
// as one rsp transaction with last on the final one, or one "empty" status.
// An insert into a full store is dropped and answered with status "full".
// Every insert answers with one transaction once the store is sorted again.
// Sequence: an insert writes the entry, then runs a full heapsort with a
// build phase and an extract phase. Each sift-down level reads the left
// child, reads the right child, then compares and writes; the sifted entry
// is held in a register and written once at the end. A full or empty
// answer goes through the response state into the response register; a
// dump reads each entry from memory, then loads it into the response
// register, one entry at a time.
// The response register holds while rsp.ready is low; the sequencer waits.
// One request is worked at a time; req.ready is high only in the idle state
// while the response register is free or draining.
// Reset (synchronous, active high) clears the entry count, the state and
// the response valid; the memory contents are left as they are and are never read unwritten.
module heapsort_record_store_by_key #(
   parameter int CAPACITY = 32
) (
   input logic clock,
   input logic reset,
   hsrs_req_if.sink   req,
   hsrs_rsp_if.source rsp
);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = hsrs_pkg::IdWidth + hsrs_pkg::KeyWidth;

   typedef enum logic [3:0] {
      S_IDLE, S_BUILD, S_SIFT_RD, S_SIFT_LD, S_SIFT_L, S_SIFT_R, S_SIFT_C,
      S_EXTRACT, S_EXT_R0, S_EXT_RL, S_EXT_C, S_DUMP_RD, S_DUMP_OUT, S_RESP
   } state_type;

   // Entry memory, one write port, registered read (read-first).
   logic [EW-1:0] mem [CAPACITY];
   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [EW-1:0] wdata, rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   state_type     state_ff;
   logic [CW-1:0] count_ff, heap_n_ff, build_ff, idx_ff;
   logic [CW-1:0] node_ff, big_ff;
   logic [EW-1:0] ent_i_ff, ent_big_ff;
   logic          extract_ff;
   hsrs_pkg::rsp_type rsp_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;

   logic [CW:0] lc, rc, heap_x;
   assign lc     = {node_ff, 1'b1};
   assign rc     = {node_ff, 1'b0} + {{(CW-1){1'b0}}, 2'b10};
   assign heap_x = {1'b0, heap_n_ff};

   logic [hsrs_pkg::KeyWidth-1:0] key_c, rd_key, big_key;
   assign key_c = (req.payload.new_key > hsrs_pkg::KeyMax) ? hsrs_pkg::KeyMax
                                                           : req.payload.new_key;
   assign rd_key  = rdata_ff[hsrs_pkg::KeyWidth-1:0];
   assign big_key = ent_big_ff[hsrs_pkg::KeyWidth-1:0];

   // Child selection: left first, right against the updated winner, strict >.
   logic          take_l, take_r, sift_done, leaf, accept, rsp_free;
   logic [CW-1:0] sel_big;
   logic [EW-1:0] sel_ent;
   assign take_l    = (lc < heap_x) && (rd_key > big_key);
   assign take_r    = (rc < heap_x) && (rd_key > big_key);
   assign sel_big   = take_r ? rc[CW-1:0] : big_ff;
   assign sel_ent   = take_r ? rdata_ff : ent_big_ff;
   assign sift_done = sel_big == node_ff;
   assign leaf      = lc >= heap_x;
   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // Status of the single answer to a request taken in idle.
   hsrs_pkg::status_type idle_status;
   always_comb begin
      idle_status = hsrs_pkg::ST_INSERTED;
      if (req.payload.kind == hsrs_pkg::KIND_DUMP) idle_status = hsrs_pkg::ST_EMPTY;
      else if (count_ff >= CW'(CAPACITY)) idle_status = hsrs_pkg::ST_FULL;
   end

   // Response valid: set on load, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if ((state_ff == S_RESP || state_ff == S_DUMP_OUT) && rsp_free) rsp_valid_in = 1'b1;
   end

   // Memory port control.
   always_comb begin
      we    = 1'b0;
      waddr = node_ff[AW-1:0];
      wdata = ent_i_ff;
      raddr = idx_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            we    = accept && req.payload.kind == hsrs_pkg::KIND_INSERT
                    && count_ff < CW'(CAPACITY);
            waddr = count_ff[AW-1:0];
            wdata = {req.payload.new_id, key_c};
         end
         S_SIFT_RD: raddr = node_ff[AW-1:0];
         S_SIFT_LD: raddr = lc[AW-1:0];
         S_SIFT_L: begin
            // no children left: the held entry lands here
            raddr = lc[AW-1:0];
            we    = leaf;
         end
         S_SIFT_R:  raddr = rc[AW-1:0];
         S_SIFT_C: begin
            we    = 1'b1;
            wdata = sift_done ? ent_i_ff : sel_ent;
         end
         S_EXT_R0:  raddr = '0;
         S_EXT_RL: begin
            // old root moves to the end of the heap
            raddr = idx_ff[AW-1:0];
            we    = 1'b1;
            waddr = idx_ff[AW-1:0];
            wdata = rdata_ff;
         end
         default: ;
      endcase
   end

   // Sequencer: build, sift-down, extract, dump, response.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  rsp_ff <= '{status: idle_status, out_id: '0, out_key: '0, last: 1'b1};
                  if (req.payload.kind == hsrs_pkg::KIND_DUMP) begin
                     if (count_ff == '0) state_ff <= S_RESP;
                     else begin
                        idx_ff   <= count_ff - CW'(1);
                        state_ff <= S_DUMP_RD;
                     end
                  end else if (count_ff >= CW'(CAPACITY)) begin
                     state_ff <= S_RESP;
                  end else begin
                     count_ff   <= count_ff + CW'(1);
                     heap_n_ff  <= count_ff + CW'(1);
                     build_ff   <= (count_ff + CW'(1)) >> 1;
                     idx_ff     <= count_ff + CW'(1);
                     extract_ff <= 1'b0;
                     state_ff   <= S_BUILD;
                  end
               end
            end
            S_BUILD: begin
               if (build_ff == '0) begin
                  extract_ff <= 1'b1;
                  state_ff   <= S_EXTRACT;
               end else begin
                  node_ff  <= build_ff - CW'(1);
                  build_ff <= build_ff - CW'(1);
                  state_ff <= S_SIFT_RD;
               end
            end
            S_SIFT_RD: state_ff <= S_SIFT_LD;
            S_SIFT_LD: begin
               ent_i_ff   <= rdata_ff;
               ent_big_ff <= rdata_ff;
               big_ff     <= node_ff;
               state_ff   <= S_SIFT_R;
            end
            S_SIFT_L: begin
               if (leaf) state_ff <= extract_ff ? S_EXTRACT : S_BUILD;
               else state_ff <= S_SIFT_R;
            end
            S_SIFT_R: begin
               if (take_l) begin
                  ent_big_ff <= rdata_ff;
                  big_ff     <= lc[CW-1:0];
               end
               state_ff <= S_SIFT_C;
            end
            S_SIFT_C: begin
               if (sift_done) begin
                  state_ff <= extract_ff ? S_EXTRACT : S_BUILD;
               end else begin
                  node_ff    <= sel_big;
                  big_ff     <= sel_big;
                  ent_big_ff <= ent_i_ff;
                  state_ff   <= S_SIFT_L;
               end
            end
            S_EXTRACT: begin
               if (idx_ff <= CW'(1)) state_ff <= S_RESP;
               else begin
                  idx_ff   <= idx_ff - CW'(1);
                  state_ff <= S_EXT_R0;
               end
            end
            S_EXT_R0: state_ff <= S_EXT_RL;
            S_EXT_RL: state_ff <= S_EXT_C;
            S_EXT_C: begin
               // old last entry sifts down from the root; heap shrinks to idx
               ent_i_ff   <= rdata_ff;
               ent_big_ff <= rdata_ff;
               node_ff    <= '0;
               big_ff     <= '0;
               heap_n_ff  <= idx_ff;
               state_ff   <= S_SIFT_L;
            end
            S_DUMP_RD: state_ff <= S_DUMP_OUT;
            S_DUMP_OUT: begin
               if (rsp_free) begin
                  rsp_ff <= '{status: hsrs_pkg::ST_ENTRY,
                              out_id: rdata_ff[EW-1:hsrs_pkg::KeyWidth],
                              out_key: rd_key,
                              last: idx_ff == '0};
                  if (idx_ff == '0) state_ff <= S_IDLE;
                  else begin
                     idx_ff   <= idx_ff - CW'(1);
                     state_ff <= S_DUMP_RD;
                  end
               end
            end
            S_RESP: if (rsp_free) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req.ready   = state_ff == S_IDLE && rsp_free;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;
endmodule

// File: tb/heapsort_record_store_by_key_test.sv
// Testbench: heapsort record store checked against a behavioral sort model.
`timescale 1ns / 1ps

module heapsort_record_store_by_key_test;
   localparam int Capacity   = 32;
   localparam int CycleLimit = 1000000;

   typedef logic [hsrs_pkg::IdWidth-1:0]  id_type;
   typedef logic [hsrs_pkg::KeyWidth-1:0] key_type;

   typedef struct {
      id_type  id;
      key_type key;
   } entry_type;

   // directed row: request plus optional typed-in answer for the last predicted result
   typedef struct {
      hsrs_pkg::req_type    item;
      logic                 fixed;
      hsrs_pkg::status_type status;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   error_count = 0;

   hsrs_req_if req_ch ();
   hsrs_rsp_if rsp_ch ();

   heapsort_record_store_by_key #(.CAPACITY(Capacity)) i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   // model state and pending answers
   entry_type         sorted_records [Capacity];
   int                record_count = 0;
   hsrs_pkg::rsp_type pending_rsp [$];
   row_type           directed_rows [$];

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic void swap_records(int a, int b);
      entry_type t;
      t = sorted_records[a];
      sorted_records[a] = sorted_records[b];
      sorted_records[b] = t;
   endfunction

   function automatic void sift_record(int n, int start);
      int node;
      int big;
      node = start;
      forever begin
         big = node;
         if (2 * node + 1 < n && sorted_records[2 * node + 1].key > sorted_records[big].key)
            big = 2 * node + 1;
         if (2 * node + 2 < n && sorted_records[2 * node + 2].key > sorted_records[big].key)
            big = 2 * node + 2;
         if (big == node) return;
         swap_records(node, big);
         node = big;
      end
   endfunction

   function automatic void expect_rsp(hsrs_pkg::rsp_type r);
      pending_rsp.insert(pending_rsp.size(), r);
   endfunction

   // work out the answers to one request, updating the model store
   function automatic void predict_answers(hsrs_pkg::req_type item);
      hsrs_pkg::rsp_type r;
      entry_type e;
      r = '0;
      r.last = 1'b1;
      if (item.kind == hsrs_pkg::KIND_INSERT) begin
         if (record_count >= Capacity) begin
            r.status = hsrs_pkg::ST_FULL;
         end else begin
            e.id  = item.new_id;
            e.key = (item.new_key > hsrs_pkg::KeyMax) ? hsrs_pkg::KeyMax : item.new_key;
            sorted_records[record_count] = e;
            record_count++;
            for (int i = record_count / 2; i > 0; i--) sift_record(record_count, i - 1);
            for (int i = record_count; i > 1; i--) begin
               swap_records(0, i - 1);
               sift_record(i - 1, 0);
            end
            r.status = hsrs_pkg::ST_INSERTED;
         end
         expect_rsp(r);
      end else if (record_count == 0) begin
         r.status = hsrs_pkg::ST_EMPTY;
         expect_rsp(r);
      end else begin
         for (int i = record_count; i > 0; i--) begin
            r.status  = hsrs_pkg::ST_ENTRY;
            r.out_id  = sorted_records[i - 1].id;
            r.out_key = sorted_records[i - 1].key;
            r.last    = (i == 1);
            expect_rsp(r);
         end
      end
   endfunction

   // receiver: stalls on a slowly changing pattern
   int stall_mode = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ch.ready <= (cycle_count % 7 < 2);
         endcase
      end
   end

   // compare each accepted result transaction with the oldest expectation
   always @(posedge clock) begin
      hsrs_pkg::rsp_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result transaction");
            error_count++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_ch.payload.status !== e.status) begin
               $error("status: expected %0d, actual %0d", e.status, rsp_ch.payload.status);
               error_count++;
            end
            if (rsp_ch.payload.out_id !== e.out_id) begin
               $error("out_id: expected %0h, actual %0h", e.out_id, rsp_ch.payload.out_id);
               error_count++;
            end
            if (rsp_ch.payload.out_key !== e.out_key) begin
               $error("out_key: expected %0d, actual %0d", e.out_key, rsp_ch.payload.out_key);
               error_count++;
            end
            if (rsp_ch.payload.last !== e.last) begin
               $error("last: expected %0d, actual %0d", e.last, rsp_ch.payload.last);
               error_count++;
            end
         end
      end
   end

   // drive one request transaction and predict it at acceptance
   task automatic send_request(hsrs_pkg::req_type item, logic fixed,
                               hsrs_pkg::status_type st);
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_answers(item);
      if (fixed && pending_rsp.size() > 0 && pending_rsp[$].status != st) begin
         $error("status: expected %0d, actual %0d", st, pending_rsp[$].status);
         error_count++;
      end
   endtask

   task automatic idle_cycles(int n);
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic hsrs_pkg::req_type make_req(logic kind, id_type id, key_type key);
      hsrs_pkg::req_type r;
      r.kind = kind;
      r.new_id = id;
      r.new_key = key;
      return r;
   endfunction

   function automatic void add_row(hsrs_pkg::req_type item, logic fixed,
                                   hsrs_pkg::status_type st);
      row_type r;
      r.item = item;
      r.fixed = fixed;
      r.status = st;
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   // stimulus
   initial begin
      int burst;
      int wait_count;
      hsrs_pkg::req_type item;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty dump, extremes, saturation, ties
      add_row(make_req(hsrs_pkg::KIND_DUMP, '0, '0), 1'b1, hsrs_pkg::ST_EMPTY);
      add_row(make_req(hsrs_pkg::KIND_INSERT, '0, '0), 1'b1, hsrs_pkg::ST_INSERTED);
      add_row(make_req(hsrs_pkg::KIND_INSERT, '1, hsrs_pkg::KeyMax), 1'b1,
              hsrs_pkg::ST_INSERTED);
      add_row(make_req(hsrs_pkg::KIND_INSERT, 32'h5555_aaaa, '1), 1'b1,
              hsrs_pkg::ST_INSERTED);
      add_row(make_req(hsrs_pkg::KIND_INSERT, 32'haaaa_5555, 9'd401), 1'b0,
              hsrs_pkg::ST_INSERTED);
      add_row(make_req(hsrs_pkg::KIND_INSERT, 32'h0000_0011, 9'd200), 1'b0,
              hsrs_pkg::ST_INSERTED);
      add_row(make_req(hsrs_pkg::KIND_INSERT, 32'h0000_0022, 9'd200), 1'b0,
              hsrs_pkg::ST_INSERTED);
      add_row(make_req(hsrs_pkg::KIND_INSERT, 32'h0000_0033, 9'd200), 1'b0,
              hsrs_pkg::ST_INSERTED);
      add_row(make_req(hsrs_pkg::KIND_DUMP, '1, '1), 1'b0, hsrs_pkg::ST_ENTRY);
      foreach (directed_rows[i])
         send_request(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].status);

      // fill to capacity, then hit the full case
      while (record_count < Capacity)
         send_request(make_req(hsrs_pkg::KIND_INSERT, $urandom,
                               key_type'($urandom_range(0, 2) * 200)), 1'b0,
                      hsrs_pkg::ST_INSERTED);
      send_request(make_req(hsrs_pkg::KIND_INSERT, $urandom, 9'd5), 1'b1, hsrs_pkg::ST_FULL);
      send_request(make_req(hsrs_pkg::KIND_DUMP, 32'd0, 9'd0), 1'b0, hsrs_pkg::ST_ENTRY);
      idle_cycles(1);

      // random: reset-free, so the store stays full after the first fill;
      // about one in four requests a dump, so full and dump paths both get traffic
      for (int n = 0; n < 400; ) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst && n < 400; b++, n++) begin
            item.kind    = ($urandom_range(0, 3) == 0);
            item.new_id  = $urandom;
            item.new_key = ($urandom_range(0, 9) == 0) ? key_type'($urandom)
                                                       : key_type'($urandom_range(0, 400));
            send_request(item, 1'b0, hsrs_pkg::ST_INSERTED);
         end
         if ($urandom_range(0, 1)) idle_cycles($urandom_range(1, 20));
      end
      req_ch.valid <= 1'b0;

      wait_count = 0;
      while (pending_rsp.size() > 0 && wait_count < 200000) begin
         @(posedge clock);
         wait_count++;
      end
      repeat (700) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// File: sim.f
hdl/hsrs_pkg.sv
hdl/hsrs_req_if.sv
hdl/hsrs_rsp_if.sv
hdl/heapsort_record_store_by_key.sv
tb/heapsort_record_store_by_key_test.sv
